@@ hw/rtl/rmq_pkg.sv @@
`timescale 1ns / 1ps
package rmq_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FIELD_W   = 18;
	localparam int ONE       = 1 << FRAC_BITS;

	// signed sums and differences of two entries, and their magnitudes
	localparam int NUM_W = FIELD_W + 1;
	localparam int MAG_W = FIELD_W + 1;

	// radicand: 1 + three entries, signed
	localparam int RAD_W  = (FIELD_W + 3 > FRAC_BITS + 3) ? FIELD_W + 3 : FRAC_BITS + 3;
	localparam int SQ_RAW = RAD_W - 1 + FRAC_BITS - 2;
	localparam int SQ_W   = SQ_RAW + (SQ_RAW % 2);
	localparam int R_W    = SQ_W / 2;
	localparam int RM_W   = R_W + 3;

	// divider: S = 4*c, quotient bits FRAC_BITS..0
	localparam int S_W  = R_W + 2;
	localparam int DR_W = ((S_W > MAG_W) ? S_W : MAG_W) + 1;
	localparam int Q_W  = FRAC_BITS + 1;

	localparam int IN_W   = 9 * FIELD_W;
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W  = 4 * FIELD_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	typedef logic [1:0] br_t;
	localparam br_t BR_TRACE = 2'd0;
	localparam br_t BR_X     = 2'd1;
	localparam br_t BR_Y     = 2'd2;
	localparam br_t BR_Z     = 2'd3;

	// the three divided components, in x, y, z, w order with the main one skipped
	typedef struct packed {
		br_t                   br;
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
	} side_t;

	typedef struct packed {
		br_t                 br;
		logic [2:0]          neg;
		logic [R_W-1:0]      c;
		logic                zero;
		logic [2:0]          ovf;
		logic [2:0][Q_W-1:0] q;
	} dv_t;

endpackage

@@ hw/rtl/rmq_front.sv @@
`timescale 1ns / 1ps
module rmq_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [rmq_pkg::IN_W-1:0] in_data,
	output logic                     valid_s1,
	output logic [rmq_pkg::SQ_W-1:0] rad_s1,
	output rmq_pkg::side_t           side_s1
);
	import rmq_pkg::*;

	localparam logic signed [RAD_W-1:0] ONE_R = RAD_W'(ONE);

	logic signed [FIELD_W-1:0] a [9];
	logic signed [RAD_W-1:0]   tr;
	logic signed [RAD_W-1:0]   rad;
	logic signed [RAD_W-1:0]   r0, r4, r8;
	logic signed [NUM_W-1:0]   e [9];
	logic signed [NUM_W-1:0]   num [3];
	logic [SQ_W-1:0]           rad_n;
	br_t                       br;
	side_t                     side;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			a[i] = in_data[i*FIELD_W +: FIELD_W];
			e[i] = NUM_W'(a[i]);
		end
		r0 = RAD_W'(a[0]);
		r4 = RAD_W'(a[4]);
		r8 = RAD_W'(a[8]);
		tr = r0 + r4 + r8;

		if (tr > 0)
			br = BR_TRACE;
		else if (a[0] > a[4] && a[0] > a[8])
			br = BR_X;
		else if (a[4] > a[8])
			br = BR_Y;
		else
			br = BR_Z;

		case (br)
			BR_TRACE: begin
				rad    = ONE_R + tr;
				num[0] = e[7] - e[5];
				num[1] = e[2] - e[6];
				num[2] = e[3] - e[1];
			end
			BR_X: begin
				rad    = ONE_R + r0 - r4 - r8;
				num[0] = e[1] + e[3];
				num[1] = e[2] + e[6];
				num[2] = e[7] - e[5];
			end
			BR_Y: begin
				rad    = ONE_R + r4 - r0 - r8;
				num[0] = e[1] + e[3];
				num[1] = e[5] + e[7];
				num[2] = e[2] - e[6];
			end
			default: begin
				rad    = ONE_R + r8 - r0 - r4;
				num[0] = e[2] + e[6];
				num[1] = e[5] + e[7];
				num[2] = e[3] - e[1];
			end
		endcase

		// non-positive radicand gives a zero root
		if (rad > 0)
			rad_n = SQ_W'(rad[RAD_W-2:0]) << (FRAC_BITS - 2);
		else
			rad_n = '0;

		side.br = br;
		for (int l = 0; l < 3; l++) begin
			side.neg[l] = num[l][NUM_W-1];
			side.mag[l] = MAG_W'(num[l][NUM_W-1] ? -num[l] : num[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= rad_n;
			side_s1 <= side;
		end
	end

endmodule

@@ hw/rtl/rmq_sqrt.sv @@
`timescale 1ns / 1ps
module rmq_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [rmq_pkg::SQ_W-1:0] in_rad,
	input  rmq_pkg::side_t           in_side,
	output logic                     out_valid,
	output logic [rmq_pkg::R_W-1:0]  out_root,
	output rmq_pkg::side_t           out_side
);
	import rmq_pkg::*;

	// one result bit per stage, two radicand bits consumed per stage
	logic                sq_v_s    [R_W];
	logic [RM_W-1:0]     sq_rem_s  [R_W];
	logic [R_W-1:0]      sq_root_s [R_W];
	logic [SQ_W-1:0]     sq_rad_s  [R_W];
	side_t               sq_side_s [R_W];

	for (genvar k = 0; k < R_W; k++) begin : g_st
		logic            v_in;
		logic [RM_W-1:0] rem_in;
		logic [R_W-1:0]  root_in;
		logic [SQ_W-1:0] rad_in;
		side_t           side_in;
		logic [RM_W-1:0] rem_sh;
		logic [RM_W-1:0] trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = in_rad;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = sq_v_s[k-1];
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign rad_in  = sq_rad_s[k-1];
			assign side_in = sq_side_s[k-1];
		end

		always_comb begin
			rem_sh = {rem_in[RM_W-3:0], rad_in[SQ_W-1 -: 2]};
			trial  = RM_W'({root_in, 2'b01});
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[k] <= 1'b0;
			else if (en)
				sq_v_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[k]  <= ge ? rem_sh - trial : rem_sh;
				sq_root_s[k] <= {root_in[R_W-2:0], ge};
				sq_rad_s[k]  <= rad_in << 2;
				sq_side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = sq_v_s[R_W-1];
	assign out_root  = sq_root_s[R_W-1];
	assign out_side  = sq_side_s[R_W-1];

endmodule

@@ hw/rtl/rmq_div.sv @@
`timescale 1ns / 1ps
module rmq_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [rmq_pkg::R_W-1:0] in_c,
	input  rmq_pkg::side_t          in_side,
	output logic                    out_valid,
	output rmq_pkg::dv_t            out_dv
);
	import rmq_pkg::*;

	// three restoring dividers in lockstep, one quotient bit per stage
	logic            dv_v_s   [Q_W];
	dv_t             dv_s     [Q_W];
	logic [DR_W-1:0] dv_rem_s [Q_W][3];

	for (genvar j = 0; j < Q_W; j++) begin : g_st
		logic            v_in;
		dv_t             d_in;
		logic [DR_W-1:0] r    [3];
		logic [DR_W-1:0] s_ext;
		logic [DR_W-1:0] rem  [3];
		dv_t             d_out;

		if (j == 0) begin : g_first
			always_comb begin
				v_in      = in_valid;
				d_in.br   = in_side.br;
				d_in.neg  = in_side.neg;
				d_in.c    = in_c;
				d_in.zero = (in_c == '0);
				d_in.q    = '0;
				for (int l = 0; l < 3; l++) begin
					r[l]        = DR_W'(in_side.mag[l]);
					// quotient at or above twice one: saturate
					d_in.ovf[l] = r[l] >= DR_W'({in_c, 3'b000});
				end
			end
		end else begin : g_next
			always_comb begin
				v_in = dv_v_s[j-1];
				d_in = dv_s[j-1];
				for (int l = 0; l < 3; l++)
					r[l] = {dv_rem_s[j-1][l][DR_W-2:0], 1'b0};
			end
		end

		always_comb begin
			s_ext = DR_W'({d_in.c, 2'b00});
			d_out = d_in;
			for (int l = 0; l < 3; l++) begin
				if (r[l] >= s_ext) begin
					rem[l]      = r[l] - s_ext;
					d_out.q[l]  = {d_in.q[l][Q_W-2:0], 1'b1};
				end else begin
					rem[l]      = r[l];
					d_out.q[l]  = {d_in.q[l][Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[j] <= 1'b0;
			else if (en)
				dv_v_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j] <= d_out;
				for (int l = 0; l < 3; l++)
					dv_rem_s[j][l] <= rem[l];
			end
		end
	end

	assign out_valid = dv_v_s[Q_W-1];
	assign out_dv    = dv_s[Q_W-1];

endmodule

@@ hw/rtl/rmq_back.sv @@
`timescale 1ns / 1ps
module rmq_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  rmq_pkg::dv_t              in_dv,
	output logic                      out_valid_q,
	output logic [rmq_pkg::OUT_W-1:0] out_data_q,
	output rmq_pkg::br_t              out_br_q
);
	import rmq_pkg::*;

	localparam logic [Q_W-1:0] ONE_Q = Q_W'(ONE);
	localparam logic [R_W:0]   ONE_C = (R_W + 1)'(ONE);

	logic [Q_W-1:0]     mag [3];
	logic [FIELD_W-1:0] val [3];
	logic [FIELD_W-1:0] main_v;
	logic [FIELD_W-1:0] qx, qy, qz, qw;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (in_dv.zero)
				mag[l] = '0;
			else if (in_dv.ovf[l] || in_dv.q[l] > ONE_Q)
				mag[l] = ONE_Q;
			else
				mag[l] = in_dv.q[l];
			// widen before negating so minus one keeps its sign bit
			val[l] = in_dv.neg[l] ? -FIELD_W'(mag[l]) : FIELD_W'(mag[l]);
		end

		main_v = ({1'b0, in_dv.c} > ONE_C) ? FIELD_W'(ONE) : FIELD_W'(in_dv.c);

		case (in_dv.br)
			BR_TRACE: begin
				qx = val[0]; qy = val[1]; qz = val[2]; qw = main_v;
			end
			BR_X: begin
				qx = main_v; qy = val[0]; qz = val[1]; qw = val[2];
			end
			BR_Y: begin
				qx = val[0]; qy = main_v; qz = val[1]; qw = val[2];
			end
			default: begin
				qx = val[0]; qy = val[1]; qz = main_v; qw = val[2];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {qw, qz, qy, qx};
			out_br_q   <= in_dv.br;
		end
	end

endmodule

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
`timescale 1ns / 1ps
// Rotation matrix to unit quaternion, trace test then largest diagonal entry,
// signed Q1.16 in and out. One matrix is taken per cycle unless a result is
// held at the output; the path is 36 register stages: one decode stage
// (branch choice, radicand, the three sums or differences), 17 square root
// stages at one root bit each, 17 divider stages at one quotient bit each for
// the three divided components side by side, and the output register. The
// whole pipeline holds while a result waits at the output, so s_tready
// follows m_tready whenever the output register is full. Components saturate
// to plus or minus one; m_tuser carries the branch code.
module rotation_matrix_to_quaternion (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 bits each), zero pad
	input  logic [rmq_pkg::IN_TW-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// quat_x, quat_y, quat_z, quat_w (18 bits each), no pad
	output logic [rmq_pkg::OUT_TW-1:0]  m_tdata,
	// branch_taken
	output logic [1:0]                  m_tuser
);
	import rmq_pkg::*;

	logic            en;
	logic            f_valid;
	logic [SQ_W-1:0] f_rad;
	side_t           f_side;
	logic            sq_valid;
	logic [R_W-1:0]  sq_root;
	side_t           sq_side;
	logic            dv_valid;
	dv_t             dv;
	logic [OUT_W-1:0] out_data;
	br_t             out_br;

	// advance everything unless a result is held at the output
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	rmq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_data  (s_tdata[IN_W-1:0]),
		.valid_s1 (f_valid),
		.rad_s1   (f_rad),
		.side_s1  (f_side)
	);

	rmq_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_rad    (f_rad),
		.in_side   (f_side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	rmq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_c      (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.out_dv    (dv)
	);

	rmq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (dv_valid),
		.in_dv       (dv),
		.out_valid_q (m_tvalid),
		.out_data_q  (out_data),
		.out_br_q    (out_br)
	);

	assign m_tdata = OUT_TW'(out_data);
	assign m_tuser = out_br;

endmodule
